[rtl/core/ppu_pkg.sv]
// ----------------------------------------------------------------------------
// ppu_pkg
// shared types, codes and helpers of the particle pool update block
// ----------------------------------------------------------------------------
package ppu_pkg;

    // command codes carried in s_tuser
    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // fixed field widths
    localparam int CFG_W       = 7;
    localparam int IDX_W       = 6;
    localparam int LIFE_W      = 24;
    localparam int SCALE_W     = 16;
    localparam int POS_W       = 32;
    localparam int DELTA_W     = 23;
    localparam int IN_TDATA_W  = 256;
    localparam int OUT_TDATA_W = 144;

    // input item queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // reset contents of a slot
    localparam logic [LIFE_W-1:0]  LIFE_RESET  = 24'hFFF000;    // -1.0 in q12.12
    localparam logic [LIFE_W-1:0]  LIFE_MIN    = 24'h800000;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'h0100;      // 1.0 in q8.8
    localparam logic [POS_W-1:0]   POS_RESET   = 32'hF0BD_C000; // -256000000, offscreen

    typedef struct packed {
        logic [POS_W-1:0] z;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] x;
    } vec3_t;

    // what a tick reads and rewrites for every slot
    typedef struct packed {
        logic [LIFE_W-1:0]  life;
        logic [SCALE_W-1:0] scale;
        vec3_t              pos;
    } slot_t;

    typedef struct packed {
        slot_t state;
        vec3_t vel;
    } spawn_t;

    typedef struct packed {
        logic               kind;
        spawn_t             spawn;
        logic [DELTA_W-1:0] delta;
    } item_t;

    // saturating add of two q24.8 values
    function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
        logic [POS_W:0] s;
        s = {a[POS_W-1], a} + {b[POS_W-1], b};
        if (s[POS_W] != s[POS_W-1]) begin
            sat_add = s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            sat_add = s[POS_W-1:0];
        end
    endfunction

endpackage

[rtl/core/ppu_front.sv]
// ----------------------------------------------------------------------------
// ppu_front
// input stage: unpacks and classifies words, holds them in a short queue
// ----------------------------------------------------------------------------
module ppu_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [ppu_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tuser,
    output logic                               q_valid,
    input  logic                               q_ready,
    output ppu_pkg::item_t                     q_item
);

    localparam int QPW = $clog2(ppu_pkg::QUEUE_DEPTH);
    localparam int QFW = $clog2(ppu_pkg::QUEUE_DEPTH + 1);

    ppu_pkg::item_t   q_mem [ppu_pkg::QUEUE_DEPTH];
    ppu_pkg::item_t   in_item;
    logic [QPW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QFW-1:0]   fill_reg;
    logic             do_wr, do_rd;

    // field split, lowest bits first
    always_comb begin
        in_item                   = '0;
        in_item.kind              = s_tuser;
        in_item.spawn.state.life  = s_tdata[23:0];
        in_item.spawn.state.scale = s_tdata[39:24];
        in_item.spawn.state.pos.x = s_tdata[71:40];
        in_item.spawn.state.pos.y = s_tdata[103:72];
        in_item.spawn.state.pos.z = s_tdata[135:104];
        in_item.spawn.vel.x       = s_tdata[167:136];
        in_item.spawn.vel.y       = s_tdata[199:168];
        in_item.spawn.vel.z       = s_tdata[231:200];
        in_item.delta             = s_tdata[254:232];
        // a tick carries no particle, a push no delta
        if (s_tuser == ppu_pkg::CMD_TICK) begin
            in_item.spawn = '0;
        end else begin
            in_item.delta = '0;
        end
    end

    assign s_tready = (fill_reg != QFW'(ppu_pkg::QUEUE_DEPTH));
    assign q_valid  = (fill_reg != '0);
    assign q_item   = q_mem[rd_ptr_reg];
    assign do_wr    = s_tvalid && s_tready;
    assign do_rd    = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= wr_ptr_reg + QPW'(1);
            end
            if (do_rd) begin
                rd_ptr_reg <= rd_ptr_reg + QPW'(1);
            end
            if (do_wr && !do_rd) begin
                fill_reg <= fill_reg + QFW'(1);
            end else if (!do_wr && do_rd) begin
                fill_reg <= fill_reg - QFW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

[rtl/core/ppu_back.sv]
// ----------------------------------------------------------------------------
// ppu_back
// execution stage: spawn buffer, slot memories, tick walk and output register
// ----------------------------------------------------------------------------
module ppu_back #(
    parameter int POOL_SLOTS  = 64,
    parameter int SPAWN_DEPTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  ppu_pkg::item_t                      q_item,
    input  logic [$clog2(POOL_SLOTS+1)-1:0]     limit,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ppu_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast
);

    localparam int IW  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int LW  = $clog2(POOL_SLOTS + 1);
    localparam int SAW = (SPAWN_DEPTH > 1) ? $clog2(SPAWN_DEPTH) : 1;
    localparam int CW  = $clog2(SPAWN_DEPTH + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    // memories
    ppu_pkg::slot_t  slot_mem  [POOL_SLOTS];
    ppu_pkg::vec3_t  vel_mem   [POOL_SLOTS];
    ppu_pkg::spawn_t spawn_mem [SPAWN_DEPTH];

    // control
    logic                         state_reg;
    logic [LW-1:0]                limit_reg;
    logic [LW-1:0]                issue_reg;
    logic [CW-1:0]                count_reg, used_reg, used_next;
    logic                         b_valid_reg;
    logic [POOL_SLOTS-1:0]        slot_init_reg;
    logic                         m_valid_reg;

    // payload
    logic [ppu_pkg::DELTA_W-1:0]  delta_reg;
    logic [IW-1:0]                b_idx_reg;
    logic                         b_last_reg;
    logic                         rd_init_reg;
    ppu_pkg::slot_t               rd_slot_reg;
    ppu_pkg::vec3_t               rd_vel_reg;
    ppu_pkg::spawn_t              spawn_rd_reg;
    logic [ppu_pkg::OUT_TDATA_W-1:0] m_data_reg;
    logic                         m_spawned_reg, m_last_reg;

    logic                         pop, push_we, out_free, adv_b, load_b, issue, walk_done;
    logic [IW-1:0]                issue_idx;
    ppu_pkg::slot_t               cur, upd;
    logic [ppu_pkg::LIFE_W:0]     diff;
    logic [ppu_pkg::LIFE_W-1:0]   life_dec;
    logic                         live, refill;

    assign q_ready   = (state_reg == ST_IDLE);
    assign pop       = q_valid && q_ready;
    assign push_we   = pop && (q_item.kind == ppu_pkg::CMD_PUSH)
                       && (count_reg < CW'(SPAWN_DEPTH));
    assign out_free  = !m_valid_reg || m_tready;
    assign adv_b     = b_valid_reg && out_free;
    assign load_b    = !b_valid_reg || adv_b;
    assign issue     = (state_reg == ST_WALK) && (issue_reg < limit_reg) && load_b;
    assign walk_done = (state_reg == ST_WALK) && (issue_reg == limit_reg) && !b_valid_reg;
    assign issue_idx = issue_reg[IW-1:0];

    // slot update
    always_comb begin
        cur      = rd_init_reg ? rd_slot_reg
                   : '{life: ppu_pkg::LIFE_RESET, scale: ppu_pkg::SCALE_RESET,
                       pos: '{z: ppu_pkg::POS_RESET, y: ppu_pkg::POS_RESET,
                              x: ppu_pkg::POS_RESET}};
        diff     = {cur.life[ppu_pkg::LIFE_W-1], cur.life} - {2'b00, delta_reg};
        life_dec = (diff[ppu_pkg::LIFE_W] != diff[ppu_pkg::LIFE_W-1])
                   ? ppu_pkg::LIFE_MIN : diff[ppu_pkg::LIFE_W-1:0];
        live     = !life_dec[ppu_pkg::LIFE_W-1] && (life_dec != '0);
        refill   = !live && (used_reg < count_reg);
        upd      = cur;
        upd.life = life_dec;
        if (live) begin
            upd.pos.x = ppu_pkg::sat_add(cur.pos.x, rd_vel_reg.x);
            upd.pos.y = ppu_pkg::sat_add(cur.pos.y, rd_vel_reg.y);
            upd.pos.z = ppu_pkg::sat_add(cur.pos.z, rd_vel_reg.z);
        end else if (refill) begin
            upd = spawn_rd_reg.state;
        end
    end

    always_comb begin
        if (walk_done) begin
            used_next = '0;
        end else if (adv_b && refill) begin
            used_next = used_reg + CW'(1);
        end else begin
            used_next = used_reg;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            limit_reg     <= '0;
            issue_reg     <= '0;
            count_reg     <= '0;
            used_reg      <= '0;
            b_valid_reg   <= 1'b0;
            slot_init_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            used_reg <= used_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (pop && (q_item.kind == ppu_pkg::CMD_TICK)) begin
                        state_reg <= ST_WALK;
                        limit_reg <= limit;
                        issue_reg <= '0;
                    end else if (push_we) begin
                        count_reg <= count_reg + CW'(1);
                    end
                end
                ST_WALK: begin
                    if (walk_done) begin
                        state_reg <= ST_IDLE;
                        count_reg <= '0;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (issue) begin
                issue_reg <= issue_reg + LW'(1);
            end
            if (load_b) begin
                b_valid_reg <= issue;
            end
            if (adv_b) begin
                slot_init_reg[b_idx_reg] <= 1'b1;
                m_valid_reg              <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload and memories
    always_ff @(posedge aclk) begin
        if (pop && (q_item.kind == ppu_pkg::CMD_TICK)) begin
            delta_reg <= q_item.delta;
        end
        if (push_we) begin
            spawn_mem[count_reg[SAW-1:0]] <= q_item.spawn;
        end
        spawn_rd_reg <= spawn_mem[used_next[SAW-1:0]];
        if (issue) begin
            rd_slot_reg <= slot_mem[issue_idx];
            rd_vel_reg  <= vel_mem[issue_idx];
            rd_init_reg <= slot_init_reg[issue_idx];
            b_idx_reg   <= issue_idx;
            b_last_reg  <= ((issue_reg + LW'(1)) == limit_reg);
        end
        if (adv_b) begin
            slot_mem[b_idx_reg] <= upd;
            if (refill) begin
                vel_mem[b_idx_reg] <= spawn_rd_reg.vel;
            end
            m_data_reg    <= {2'b00, upd.pos.z, upd.pos.y, upd.pos.x, upd.scale, upd.life,
                              ppu_pkg::IDX_W'(b_idx_reg)};
            m_spawned_reg <= refill;
            m_last_reg    <= b_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_spawned_reg;
    assign m_tlast  = m_last_reg;

    a_used_le_count: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= count_reg)
        else $error("spawn entries used beyond those buffered");

    a_stage_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        b_valid_reg |-> (state_reg == ST_WALK))
        else $error("slot in flight outside a tick");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (issue_reg <= limit_reg))
        else $error("walk ran past the slot limit");

    a_tick_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        walk_done |=> ((count_reg == '0) && (used_reg == '0) && (state_reg == ST_IDLE)))
        else $error("spawn buffer not emptied after tick");

endmodule

[rtl/core/particle_pool_update.sv]
// ----------------------------------------------------------------------------
// particle_pool_update
// pool of particle slots updated per frame tick, fed by a spawn buffer
// ----------------------------------------------------------------------------
// A push word (tuser = 0) appends a particle to the spawn buffer in the
// execution stage; pushes into a full buffer are dropped. A tick word
// (tuser = 1) walks slots 0 .. particle_limit-1 through the slot memories at
// one slot per cycle while m_tready does not hold the output, one read and
// one write-back per slot; it holds the execution stage until the walk is
// done and emits one word per slot with tlast on the final one. A two-word
// queue in front keeps accepting input while a tick is being walked. No
// clearing pass is needed after reset: per-slot valid bits stand in for the
// reset contents. Configuration writes are accepted at any time but are
// meant to happen only while the block is idle.
module particle_pool_update #(
    parameter int POOL_SLOTS  = 64,
    parameter int SPAWN_DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration: particle_limit, saturated to the pool size
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ppu_pkg::CFG_W-1:0]        cfg_data,
    // input words
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // new_life[23:0], new_scale[39:24], new_pos_x[71:40], new_pos_y[103:72],
    // new_pos_z[135:104], new_vel_x[167:136], new_vel_y[199:168],
    // new_vel_z[231:200], delta_time[254:232], zero[255]
    input  logic [ppu_pkg::IN_TDATA_W-1:0]   s_tdata,
    // cmd[0]
    input  logic                             s_tuser,
    // result words
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // slot_index[5:0], slot_life[29:6], slot_scale[45:30], slot_pos_x[77:46],
    // slot_pos_y[109:78], slot_pos_z[141:110], zero[143:142]
    output logic [ppu_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // slot_spawned[0]
    output logic                             m_tuser,
    // last_slot
    output logic                             m_tlast
);

    localparam int LW = $clog2(POOL_SLOTS + 1);

    logic            limit_reg;
    logic [LW-1:0]   limit_val_reg;
    logic            q_valid, q_ready;
    ppu_pkg::item_t  q_item;

    // particle limit register, resets to the full pool
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_val_reg <= LW'(POOL_SLOTS);
            limit_reg     <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            // values above the pool size clamp to it
            limit_val_reg <= (cfg_data > ppu_pkg::CFG_W'(POOL_SLOTS))
                             ? LW'(POOL_SLOTS) : LW'(cfg_data);
            limit_reg     <= 1'b1;
        end
    end

    // front: unpack and queue words
    ppu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    // back: spawn buffer, slot walk, result register
    ppu_back #(
        .POOL_SLOTS  (POOL_SLOTS),
        .SPAWN_DEPTH (SPAWN_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .limit    (limit_reg ? limit_val_reg : LW'(POOL_SLOTS)),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
